@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define AFD_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stencil check failed");

// property checked on every edge, reset included
`define AFD_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stencil reset check failed");

`endif

@@ rtl/afd_pkg.sv @@
package afd_pkg;

  // width used for frame sizes and positions in compares
  localparam int SIZE_W = 13;
  localparam int MIN_SIZE = 5;

  typedef struct packed {
    logic signed [31:0] cur_value;
    logic signed [31:0] prev_value;
    logic [30:0]        vel_term;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] updated_value;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic               saturated;
    logic               frame_end;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_ADJOINT    = 3'd0,
    CFG_COEF_C     = 3'd1,
    CFG_COEF_AN    = 3'd2,
    CFG_COEF_AF    = 3'd3,
    CFG_COEF_RN    = 3'd4,
    CFG_COEF_RF    = 3'd5,
    CFG_ROW_TOTAL  = 3'd6,
    CFG_COL_TOTAL  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CMUL,
    ST_CRND,
    ST_VHI,
    ST_VLO,
    ST_VSUM,
    ST_FIN,
    ST_WRITE
  } afd_state_t;

endpackage

@@ rtl/acoustic_fd_stencil_update.sv @@
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_item (cur, prev, velocity)
// out     | output    | out_valid/out_stall| out_item (value, row, col, flags)
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one item at a time: accept, line store reads, then, for an interior point,
// the stencil on one shared 33x33 multiplier, then write-back.
// rst is synchronous; line stores are not cleared.
// a finished item waits in the output register while the next item is taken;
// the block holds only if a second result is ready before the first is taken.
module acoustic_fd_stencil_update #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  afd_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output afd_pkg::out_item_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import afd_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int AW  = $clog2(4 * MAX_COLS);
  localparam int PAW = $clog2(2 * MAX_COLS);
  localparam int PW  = 38;
  localparam int LW  = 72;
  localparam int FW  = 74;

  // configuration
  logic               adjoint;
  logic signed [31:0] coef_c, coef_an, coef_af, coef_rn, coef_rf;
  logic [10:0]        row_total, col_total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      adjoint   <= 1'b1;
      coef_c    <= '0;
      coef_an   <= '0;
      coef_af   <= '0;
      coef_rn   <= '0;
      coef_rf   <= '0;
      row_total <= 11'd1024;
      col_total <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ADJOINT:   adjoint   <= cfg_data[0];
        CFG_COEF_C:    coef_c    <= cfg_data;
        CFG_COEF_AN:   coef_an   <= cfg_data;
        CFG_COEF_AF:   coef_af   <= cfg_data;
        CFG_COEF_RN:   coef_rn   <= cfg_data;
        CFG_COEF_RF:   coef_rf   <= cfg_data;
        CFG_ROW_TOTAL: row_total <= cfg_data[10:0];
        CFG_COL_TOTAL: col_total <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [SIZE_W-1:0] rows, cols;
  always_comb begin
    rows = SIZE_W'(row_total);
    if (rows < SIZE_W'(MIN_SIZE)) rows = SIZE_W'(MIN_SIZE);
    else if (rows > SIZE_W'(MAX_ROWS)) rows = SIZE_W'(MAX_ROWS);
    cols = SIZE_W'(col_total);
    if (cols < SIZE_W'(MIN_SIZE)) cols = SIZE_W'(MIN_SIZE);
    else if (cols > SIZE_W'(MAX_COLS)) cols = SIZE_W'(MAX_COLS);
  end

  afd_state_t state, state_next;
  logic [RW-1:0] row_pos, r_q;
  logic [CW-1:0] col_pos, c_q;
  logic [3:0]    rd_cnt, term;
  logic          emit, interior, fend;
  logic [9:0]    orow, ocol;
  logic signed [31:0] prv_q, old;
  logic signed [31:0] u [9];
  logic [30:0]        v [9];
  logic signed [PW-1:0] p;
  logic [30:0]          vsel;
  logic signed [65:0]   acc_hi;
  logic signed [LW-1:0] lap;

  wire accept = in_valid && !in_stall;
  wire out_free = !out_valid || !out_stall;

  // position of the arriving point, with restart when beyond the frame
  logic [SIZE_W-1:0] r_n, c_n;
  always_comb begin
    r_n = SIZE_W'(row_pos);
    c_n = SIZE_W'(col_pos);
    if (r_n >= rows || c_n >= cols) begin
      r_n = '0;
      c_n = '0;
    end
  end

  // line stores
  logic [31:0] wave_mem [4 * MAX_COLS];
  logic [30:0] vel_mem  [4 * MAX_COLS];
  logic [31:0] prev_mem [2 * MAX_COLS];
  logic [31:0] wave_rd, prev_rd;
  logic [30:0] vel_rd;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [PAW-1:0] prd_addr, pwr_addr;
  logic [1:0]     slot;
  logic [CW-1:0]  col;

  // read address per read step
  always_comb begin
    slot = r_q[1:0] - 2'd2;
    col  = c_q;
    case (rd_cnt)
      4'd1: col = c_q - CW'(1);
      4'd2: col = c_q + CW'(1);
      4'd3: col = c_q - CW'(2);
      4'd4: col = c_q + CW'(2);
      4'd5: slot = r_q[1:0] - 2'd3;
      4'd6: slot = r_q[1:0] - 2'd1;
      4'd7: slot = r_q[1:0];
      default: ;
    endcase
    rd_addr  = AW'(slot) * AW'(MAX_COLS) + AW'(col);
    prd_addr = PAW'(r_q[0]) * PAW'(MAX_COLS) + PAW'(c_q);
    wr_addr  = AW'(r_q[1:0]) * AW'(MAX_COLS) + AW'(c_q);
    pwr_addr = prd_addr;
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      wave_rd <= wave_mem[rd_addr];
      vel_rd  <= vel_mem[rd_addr];
      prev_rd <= prev_mem[prd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      wave_mem[wr_addr]  <= u[8];
      vel_mem[wr_addr]   <= v[8];
      prev_mem[pwr_addr] <= prv_q;
    end
  end

  // coefficient of each stencil term
  logic signed [31:0] coef_k;
  always_comb begin
    case (term)
      4'd0:         coef_k = coef_c;
      4'd1, 4'd2:   coef_k = coef_an;
      4'd3, 4'd4:   coef_k = coef_af;
      4'd5, 4'd6:   coef_k = coef_rn;
      default:      coef_k = coef_rf;
    endcase
  end

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               mul_en;
  always_comb begin
    mul_en = 1'b1;
    case (state)
      ST_CMUL: begin
        mul_a = 33'(coef_k);
        mul_b = 33'(u[term]);
      end
      ST_VHI: begin
        mul_a = 33'(p >>> 16);
        mul_b = {2'b00, vsel};
      end
      ST_VLO: begin
        mul_a = {17'b0, p[15:0]};
        mul_b = {2'b00, vsel};
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  afd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // rounded products
  logic signed [65:0]   c_rnd, v_rnd;
  logic signed [LW-1:0] vel_res;
  always_comb begin
    c_rnd   = prod + (66'sd1 <<< 29);
    v_rnd   = prod + 66'sd32768;
    vel_res = LW'(acc_hi) + LW'(v_rnd >>> 16);
  end

  // final sum and clip; a non-interior point keeps its previous value
  logic signed [FW-1:0] full;
  logic signed [31:0]   res;
  logic                 sat;
  always_comb begin
    full = FW'(u[0]) + FW'(u[0]) - FW'(old) + FW'(lap);
    res  = old;
    sat  = 1'b0;
    if (interior) begin
      if (full > FW'(64'sh7FFFFFFF)) begin
        res = 32'sh7FFFFFFF;
        sat = 1'b1;
      end else if (full < -FW'(64'sh80000000)) begin
        res = 32'sh80000000;
        sat = 1'b1;
      end else begin
        res = 32'(full);
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  if (rd_cnt == 4'd8) state_next = interior ? ST_CMUL : ST_FIN;
      ST_CMUL:  state_next = ST_CRND;
      ST_CRND: begin
        if (!adjoint) state_next = ST_VHI;
        else if (term == 4'd8) state_next = ST_VHI;
        else state_next = ST_CMUL;
      end
      ST_VHI:   state_next = ST_VLO;
      ST_VLO:   state_next = ST_VSUM;
      ST_VSUM:  state_next = (adjoint || term == 4'd8) ? ST_FIN : ST_CMUL;
      ST_FIN:   if (out_free || !emit) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (c_n + SIZE_W'(1) >= cols) begin
        col_pos <= '0;
        row_pos <= (r_n + SIZE_W'(1) >= rows) ? '0 : RW'(r_n + SIZE_W'(1));
      end else begin
        col_pos <= CW'(c_n + SIZE_W'(1));
        row_pos <= RW'(r_n);
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rd_cnt   <= '0;
        term     <= '0;
        lap      <= '0;
        r_q      <= RW'(r_n);
        c_q      <= CW'(c_n);
        u[8]     <= in_item.cur_value;
        v[8]     <= in_item.vel_term;
        prv_q    <= in_item.prev_value;
        emit     <= (r_n >= SIZE_W'(2));
        interior <= (r_n >= SIZE_W'(4)) && (c_n >= SIZE_W'(2))
                    && (c_n + SIZE_W'(2) < cols);
        fend     <= (r_n + SIZE_W'(1) == rows) && (c_n + SIZE_W'(1) == cols);
        orow     <= 10'(r_n - SIZE_W'(2));
        ocol     <= 10'(c_n);
      end
      ST_READ: begin
        rd_cnt <= rd_cnt + 4'd1;
        if (rd_cnt != 4'd0) begin
          u[rd_cnt - 4'd1] <= wave_rd;
          v[rd_cnt - 4'd1] <= vel_rd;
        end
        if (rd_cnt == 4'd1) old <= prev_rd;
      end
      ST_CRND: begin
        if (adjoint) begin
          if (term == 4'd8) begin
            p    <= PW'(lap + LW'(c_rnd >>> 30));
            vsel <= v[0];
          end else begin
            lap  <= lap + LW'(c_rnd >>> 30);
            term <= term + 4'd1;
          end
        end else begin
          p    <= PW'(c_rnd >>> 30);
          vsel <= v[term];
        end
      end
      ST_VLO: acc_hi <= prod;
      ST_VSUM: begin
        if (adjoint) lap <= vel_res;
        else begin
          lap  <= lap + vel_res;
          term <= term + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && emit && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && emit && out_free) begin
      out_item.updated_value <= res;
      out_item.out_row       <= orow;
      out_item.out_col       <= ocol;
      out_item.saturated     <= sat;
      out_item.frame_end     <= fend;
    end
  end

endmodule

@@ rtl/afd_mul.sv @@
module afd_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

@@ rtl/afd_checker.sv @@
`include "assert_macros.svh"

module afd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input afd_pkg::out_item_t out_item
);

  wire out_sat_max = (out_item.updated_value == 32'sh7FFFFFFF);
  wire out_sat_min = (out_item.updated_value == 32'sh80000000);

  // a stalled result keeps its valid and payload
  `AFD_CHECK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_item))

  // reset leaves no result pending
  `AFD_CHECK_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

  // an accepted item keeps the block busy for the next cycle
  `AFD_CHECK(a_busy, clk, rst, in_valid && !in_stall |=> in_stall)

  // a new result only comes out of item processing
  `AFD_CHECK(a_res_busy, clk, rst, $rose(out_valid) |-> $past(in_stall))

  // a clipped value sits on a range limit
  `AFD_CHECK(a_sat_limit, clk, rst, out_valid && out_item.saturated |-> out_sat_max || out_sat_min)

endmodule

bind acoustic_fd_stencil_update afd_checker u_afd_checker (.*);

@@ tb/tb_acoustic_fd_stencil_update.sv @@
`timescale 1ns / 100ps

module tb_acoustic_fd_stencil_update;
  import afd_pkg::*;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int STUCK_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 64;

  // wavefield predictor and store of expected updates
  class stencil_board;
    logic [31:0] wave_mem [4][MAX_COLS];
    logic [30:0] vel_mem [4][MAX_COLS];
    logic [31:0] prev_mem [2][MAX_COLS];
    int unsigned row_pos, col_pos;
    bit adjoint;
    longint coef [5];
    int unsigned row_total, col_total;
    out_item_t expected_q [$];
    int errors;

    function void clear();
      row_pos = 0;
      col_pos = 0;
      adjoint = 1;
      foreach (coef[i]) coef[i] = 0;
      row_total = 1024;
      col_total = 1024;
      expected_q.delete();
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        CFG_ADJOINT: adjoint = data[0];
        CFG_COEF_C: coef[0] = longint'($signed(data));
        CFG_COEF_AN: coef[1] = longint'($signed(data));
        CFG_COEF_AF: coef[2] = longint'($signed(data));
        CFG_COEF_RN: coef[3] = longint'($signed(data));
        CFG_COEF_RF: coef[4] = longint'($signed(data));
        CFG_ROW_TOTAL: row_total = data[10:0];
        CFG_COL_TOTAL: col_total = data[10:0];
        default: ;
      endcase
    endfunction

    function int unsigned clip(int unsigned v, int unsigned maxv);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > maxv) return maxv;
      return v;
    endfunction

    // Q2.30 times Q16.16, rounded half up
    function longint cmul(longint k, longint u);
      return (k * u + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // Q16.16 velocity times Q16.16, rounded half up
    function longint vmul(longint v, longint p);
      longint hi, lo;
      hi = p >>> 16;
      lo = p - hi * 65536;
      return hi * v + ((v * lo + 32768) >>> 16);
    endfunction

    function void note_input(in_item_t it);
      int unsigned rows, cols, r, c, er;
      int unsigned s1, s2, s3, s4;
      longint old, res, lap;
      longint u [9];
      longint k [9];
      longint v [9];
      bit sat;
      out_item_t o;
      rows = clip(row_total, MAX_ROWS);
      cols = clip(col_total, MAX_COLS);
      if (row_pos >= rows || col_pos >= cols) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (r >= 2) begin
        er = r - 2;
        old = longint'($signed(prev_mem[er & 1][c]));
        res = old;
        sat = 0;
        // interior point: full stencil
        if (er >= 2 && c >= 2 && c + 2 < cols) begin
          s1 = (r - 1) & 3;
          s2 = (r - 2) & 3;
          s3 = (r - 3) & 3;
          s4 = (r - 4) & 3;
          u[0] = $signed(wave_mem[s2][c]);     v[0] = vel_mem[s2][c];     k[0] = coef[0];
          u[1] = $signed(wave_mem[s2][c - 1]); v[1] = vel_mem[s2][c - 1]; k[1] = coef[1];
          u[2] = $signed(wave_mem[s2][c + 1]); v[2] = vel_mem[s2][c + 1]; k[2] = coef[1];
          u[3] = $signed(wave_mem[s2][c - 2]); v[3] = vel_mem[s2][c - 2]; k[3] = coef[2];
          u[4] = $signed(wave_mem[s2][c + 2]); v[4] = vel_mem[s2][c + 2]; k[4] = coef[2];
          u[5] = $signed(wave_mem[s3][c]);     v[5] = vel_mem[s3][c];     k[5] = coef[3];
          u[6] = $signed(wave_mem[s1][c]);     v[6] = vel_mem[s1][c];     k[6] = coef[3];
          u[7] = $signed(wave_mem[s4][c]);     v[7] = vel_mem[s4][c];     k[7] = coef[4];
          u[8] = $signed(it.cur_value);        v[8] = it.vel_term;        k[8] = coef[4];
          lap = 0;
          if (adjoint) begin
            for (int i = 0; i < 9; i++) lap += cmul(k[i], u[i]);
            lap = vmul(v[0], lap);
          end else begin
            for (int i = 0; i < 9; i++) lap += vmul(v[i], cmul(k[i], u[i]));
          end
          res = 2 * u[0] - old + lap;
          if (res > 64'sd2147483647) begin
            res = 64'sd2147483647;
            sat = 1;
          end
          if (res < -64'sd2147483648) begin
            res = -64'sd2147483648;
            sat = 1;
          end
        end
        o.updated_value = res[31:0];
        o.out_row = er[9:0];
        o.out_col = c[9:0];
        o.saturated = sat;
        o.frame_end = (r + 1 == rows && c + 1 == cols);
        expected_q.push_back(o);
      end
      wave_mem[r & 3][c] = it.cur_value;
      vel_mem[r & 3][c] = it.vel_term;
      prev_mem[r & 1][c] = it.prev_value;
      col_pos = c + 1;
      if (col_pos >= cols) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= rows) row_pos = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result row %0d col %0d", got.out_row, got.out_col);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.updated_value !== e.updated_value) begin
        $error("updated_value exp %0d got %0d", e.updated_value, got.updated_value);
        errors++;
      end
      if (got.out_row !== e.out_row) begin
        $error("out_row exp %0d got %0d", e.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== e.out_col) begin
        $error("out_col exp %0d got %0d", e.out_col, got.out_col);
        errors++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated exp %0b got %0b", e.saturated, got.saturated);
        errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $error("frame_end exp %0b got %0b", e.frame_end, got.frame_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  stencil_board board = new();
  bit calm = 0;
  int stuck = 0;
  int rand_items = 0;

  acoustic_fd_stencil_update #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver stalls at random unless calm is set
  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_item);
    if (rst || (out_valid && !out_stall) || (in_valid && !in_stall)
        || (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_point(in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_item = it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    board.note_input(it);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    @(negedge clk);
    in_valid = 0;
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(logic [31:0] rows, logic [31:0] cols);
    write_reg(CFG_ROW_TOTAL, rows);
    write_reg(CFG_COL_TOTAL, cols);
  endtask

  task automatic set_coefs(bit adj, bit full);
    write_reg(CFG_ADJOINT, 32'(adj));
    for (int i = 1; i <= 5; i++) begin
      if (full) write_reg(cfg_reg_t'(i), $urandom());
      else write_reg(cfg_reg_t'(i), 32'($signed($urandom_range(1 << 29)) - (1 << 28)));
    end
  endtask

  function automatic logic [31:0] pick_value(bit full);
    if (full) return $urandom();
    return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
  endfunction

  // random frames; pauses for full drain once mid-frame when asked
  task automatic run_frames(int count, bit full, bit hold_mid);
    int unsigned n;
    in_item_t it;
    n = board.clip(board.row_total, MAX_ROWS) * board.clip(board.col_total, MAX_COLS);
    for (int f = 0; f < count; f++) begin
      for (int unsigned i = 0; i < n; i++) begin
        it.cur_value = pick_value(full || $urandom_range(9) < 3);
        it.prev_value = pick_value(full || $urandom_range(9) < 3);
        it.vel_term = (full || $urandom_range(9) < 3) ? 31'($urandom())
                                                      : 31'($urandom_range(1 << 18));
        send_point(it);
        rand_items++;
        if (hold_mid && f == 0 && i == n / 2) begin
          @(negedge clk);
          in_valid = 0;
          while (board.pending() != 0) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    logic [31:0] edge_vals [5];
    in_item_t it;
    int phase;
    edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff};
    board.clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: smallest frame, extreme coefficients and values
    set_frame(5, 5);
    write_reg(CFG_COEF_C, 32'h80000000);
    write_reg(CFG_COEF_AN, 32'h7fffffff);
    write_reg(CFG_COEF_AF, 32'h80000000);
    write_reg(CFG_COEF_RN, 32'h7fffffff);
    write_reg(CFG_COEF_RF, 32'h40000000);
    write_reg(CFG_ADJOINT, 1);
    for (int i = 0; i < 25; i++) begin
      it.cur_value = edge_vals[i % 5];
      it.prev_value = edge_vals[(i / 5) % 5];
      it.vel_term = (i % 2) ? 31'h7fffffff : 31'h0;
      send_point(it);
    end
    drain();

    // random phases over modes and frame sizes, out of range sizes included
    phase = 0;
    while (rand_items < 375) begin
      calm = (phase == 0);
      set_coefs(1'($urandom_range(1)), $urandom_range(3) == 0);
      if (phase == 1) set_frame($urandom_range(4), $urandom_range(4));
      else set_frame($urandom_range(5, 10), $urandom_range(5, 10));
      run_frames($urandom_range(1, 2), $urandom_range(4) == 0, phase == 1);
      drain();
      phase++;
    end
    calm = 0;

    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
